[sv/bcps_pkg.sv]
`default_nettype none

package bcps_pkg;

    localparam int DEF_TEXT_DEPTH   = 4096;
    localparam int DEF_MAX_PATTERN  = 8;
    localparam int DEF_MAX_REPORTED = 63;

    localparam int BYTE_W     = 8;
    localparam int PAT_W      = 64;
    localparam int PLEN_W     = 4;
    localparam int IDX_W      = 3;
    localparam int POS_W      = 12;
    localparam int MC_W       = 13;
    localparam int CMP_W      = 16;
    localparam int OUT_DATA_W = 48;

    localparam logic [MC_W-1:0]  MATCH_MAX = 13'h1FFF;
    localparam logic [CMP_W-1:0] CMP_MAX   = 16'hFFFF;

    localparam logic CFG_PATTERN_CHARS  = 1'b0;
    localparam logic CFG_PATTERN_LENGTH = 1'b1;

    localparam logic KIND_POSITION = 1'b0;
    localparam logic KIND_SUMMARY  = 1'b1;

    typedef struct packed {
        logic store;
        logic init;
        logic load_j;
        logic rd_win;
        logic cmp_step;
        logic count_match;
        logic emit_pos;
        logic step1;
        logic rd_next;
        logic shift_next;
        logic emit_sum;
    } cmd_t;

    typedef struct packed {
        logic window_ok;
        logic eq;
        logic j_zero;
        logic report;
        logic has_next;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } bad_char_t;

    function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] pat,
                                                   input logic [IDX_W-1:0] idx);
        pat_byte = pat[{idx, 3'b000} +: BYTE_W];
    endfunction

    // last pattern index holding c, among the first m bytes
    function automatic bad_char_t bad_char(input logic [PAT_W-1:0] pat,
                                           input logic [PLEN_W-1:0] m,
                                           input logic [BYTE_W-1:0] c);
        bad_char_t r;
        r.valid = 1'b0;
        r.idx   = '0;
        for (int i = 0; i < 8; i++) begin
            if ((PLEN_W'(i) < m) && (pat[i*BYTE_W +: BYTE_W] == c)) begin
                r.valid = 1'b1;
                r.idx   = IDX_W'(i);
            end
        end
        bad_char = r;
    endfunction

endpackage

`default_nettype wire

[sv/bcps_ctrl.sv]
`default_nettype none

module bcps_ctrl
    import bcps_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  s_tvalid,
    input  wire  s_tlast,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CMP   = 4'd4;
    localparam logic [3:0] S_MATCH = 4'd5;
    localparam logic [3:0] S_RDN   = 4'd6;
    localparam logic [3:0] S_NSH   = 4'd7;
    localparam logic [3:0] S_SUM   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.store = 1'b1;
                    if (s_tlast)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.window_ok)
                begin
                    cmd.load_j = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_SUM;
                end
            end
            S_RD:
            begin
                cmd.rd_win = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp_step = 1'b1;
                if (!sts.eq)
                begin
                    state_next = S_CHECK;
                end
                else if (sts.j_zero)
                begin
                    state_next = S_MATCH;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_MATCH:
            begin
                // hold while a position result has no room
                if (!sts.report || sts.out_free)
                begin
                    cmd.count_match = 1'b1;
                    cmd.emit_pos    = sts.report;
                    if (sts.has_next)
                    begin
                        state_next = S_RDN;
                    end
                    else
                    begin
                        cmd.step1  = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_RDN:
            begin
                cmd.rd_next = 1'b1;
                state_next  = S_NSH;
            end
            S_NSH:
            begin
                cmd.shift_next = 1'b1;
                state_next     = S_CHECK;
            end
            S_SUM:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_sum = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/bcps_dp.sv]
`default_nettype none

module bcps_dp
    import bcps_pkg::*;
#(
    parameter int TEXT_DEPTH   = DEF_TEXT_DEPTH,
    parameter int MAX_PATTERN  = DEF_MAX_PATTERN,
    parameter int MAX_REPORTED = DEF_MAX_REPORTED
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_write,
    input  wire                   cfg_index,
    input  wire [PAT_W-1:0]       cfg_data,
    input  wire [BYTE_W-1:0]      text_byte,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  wire                   out_ready,
    output logic                  out_valid,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_kind,
    output logic                  out_last
);

    localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
    localparam int LW = $clog2(TEXT_DEPTH + 1);
    localparam int SW = LW + 1;

    logic [BYTE_W-1:0] mem [TEXT_DEPTH];

    logic [PAT_W-1:0]      pat_reg;
    logic [PLEN_W-1:0]     plen_reg;
    logic [PLEN_W-1:0]     m_reg;
    logic [LW-1:0]         len_reg;
    logic [SW-1:0]         s_reg;
    logic [IDX_W-1:0]      j_reg;
    logic [MC_W-1:0]       mc_reg;
    logic [CMP_W-1:0]      cmp_reg;
    logic [BYTE_W-1:0]     rdata_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_kind_reg;
    logic                  out_last_reg;

    logic [PLEN_W-1:0] m_next;
    logic [SW-1:0]     s_next;
    logic [SW-1:0]     win_end;
    logic [AW-1:0]     rd_addr;
    logic              eq;
    bad_char_t         bc;
    logic [PLEN_W-1:0] mis_shift;
    logic [PLEN_W-1:0] nxt_shift;
    logic              out_free;

    // clamp pattern length to 1..MAX_PATTERN
    always_comb
    begin
        if (plen_reg == '0)
        begin
            m_next = PLEN_W'(1);
        end
        else if (plen_reg > PLEN_W'(MAX_PATTERN))
        begin
            m_next = PLEN_W'(MAX_PATTERN);
        end
        else
        begin
            m_next = plen_reg;
        end
    end

    assign win_end  = s_reg + SW'(m_reg);
    assign eq       = (rdata_reg == pat_byte(pat_reg, j_reg));
    assign bc       = bad_char(pat_reg, m_reg, rdata_reg);
    assign out_free = !out_valid_reg || out_ready;
    assign rd_addr  = cmd.rd_next ? AW'(win_end) : AW'(s_reg + SW'(j_reg));

    always_comb
    begin
        if (!bc.valid)
        begin
            mis_shift = PLEN_W'(j_reg) + PLEN_W'(1);
        end
        else if (bc.idx >= j_reg)
        begin
            mis_shift = PLEN_W'(1);
        end
        else
        begin
            mis_shift = PLEN_W'(j_reg - bc.idx);
        end
        nxt_shift = bc.valid ? (m_reg - PLEN_W'(bc.idx)) : (m_reg + PLEN_W'(1));
    end

    always_comb
    begin
        s_next = s_reg;
        if (cmd.init)
        begin
            s_next = '0;
        end
        else if (cmd.cmp_step && !eq)
        begin
            s_next = s_reg + SW'(mis_shift);
        end
        else if (cmd.step1)
        begin
            s_next = s_reg + SW'(1);
        end
        else if (cmd.shift_next)
        begin
            s_next = s_reg + SW'(nxt_shift);
        end
    end

    assign sts.window_ok = (win_end <= SW'(len_reg));
    assign sts.eq        = eq;
    assign sts.j_zero    = (j_reg == '0);
    assign sts.report    = (mc_reg < MC_W'(MAX_REPORTED));
    assign sts.has_next  = (win_end < SW'(len_reg));
    assign sts.out_free  = out_free;

    always_ff @(posedge clk)
    begin
        if (cmd.store && (len_reg < LW'(TEXT_DEPTH)))
        begin
            mem[AW'(len_reg)] <= text_byte;
        end
        if (cmd.rd_win || cmd.rd_next)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg       <= '0;
            plen_reg      <= PLEN_W'(1);
            m_reg         <= PLEN_W'(1);
            len_reg       <= '0;
            s_reg         <= '0;
            j_reg         <= '0;
            mc_reg        <= '0;
            cmp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PATTERN_CHARS:  pat_reg  <= cfg_data;
                    CFG_PATTERN_LENGTH: plen_reg <= cfg_data[PLEN_W-1:0];
                    default:            pat_reg  <= pat_reg;
                endcase
            end

            if (cmd.store && (len_reg < LW'(TEXT_DEPTH)))
            begin
                len_reg <= len_reg + LW'(1);
            end
            else if (cmd.emit_sum)
            begin
                len_reg <= '0;
            end

            s_reg <= s_next;

            if (cmd.init)
            begin
                m_reg   <= m_next;
                mc_reg  <= '0;
                cmp_reg <= '0;
            end
            else
            begin
                if (cmd.cmp_step && (cmp_reg != CMP_MAX))
                begin
                    cmp_reg <= cmp_reg + CMP_W'(1);
                end
                if (cmd.count_match && (mc_reg != MATCH_MAX))
                begin
                    mc_reg <= mc_reg + MC_W'(1);
                end
            end

            if (cmd.load_j)
            begin
                j_reg <= IDX_W'(m_reg - PLEN_W'(1));
            end
            else if (cmd.cmp_step && eq && (j_reg != '0))
            begin
                j_reg <= j_reg - IDX_W'(1);
            end

            if (cmd.emit_pos || cmd.emit_sum)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: position, match_count, comparisons, dropped flag
    always_ff @(posedge clk)
    begin
        if (cmd.emit_pos)
        begin
            out_data_reg <= OUT_DATA_W'(POS_W'(s_reg));
            out_kind_reg <= KIND_POSITION;
            out_last_reg <= 1'b0;
        end
        else if (cmd.emit_sum)
        begin
            out_data_reg <= OUT_DATA_W'({(mc_reg > MC_W'(MAX_REPORTED)), cmp_reg, mc_reg,
                                         POS_W'(0)});
            out_kind_reg <= KIND_SUMMARY;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

[sv/bad_character_pattern_search.sv]
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata = text_byte, s_tlast = last
// m_*       out  m_tvalid/m_tready  m_tdata = result fields, m_tuser = kind,
//                                   m_tlast = last_res
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Text loads at one beat per cycle. After the last beat the search starts with
// an init step, then each byte comparison reads the text buffer, then compares;
// each window gets a check, and each match a count step plus a read and shift
// on the byte past the window unless the window ends at the end of the text, as
// the text buffer has a single read port. The summary beat ends the run.
// Reset clears control and counters; the text buffer is not cleared.
// A stalled result port holds the search at the next beat to emit.
`default_nettype none

module bad_character_pattern_search
    import bcps_pkg::*;
#(
    parameter int TEXT_DEPTH   = DEF_TEXT_DEPTH,
    parameter int MAX_PATTERN  = DEF_MAX_PATTERN,
    parameter int MAX_REPORTED = DEF_MAX_REPORTED
)
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire [7:0]             s_tdata,   // [7:0] text_byte
    input  wire                   s_tlast,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    // [11:0] position, [24:12] match_count, [40:25] comparisons,
    // [41] positions_dropped, [47:42] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,   // [0] kind
    output logic                  m_tlast,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire                   cfg_index,
    input  wire [PAT_W-1:0]       cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bcps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bcps_dp #(
        .TEXT_DEPTH   (TEXT_DEPTH),
        .MAX_PATTERN  (MAX_PATTERN),
        .MAX_REPORTED (MAX_REPORTED)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .text_byte (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb
    import bcps_pkg::*;
();

    localparam int QUIET_LIMIT = 200000;
    localparam int HOLD_CYCLES = 500;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } text_beat_t;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] position;
        logic [MC_W-1:0]  match_count;
        logic [CMP_W-1:0] comparisons;
        logic             dropped;
        logic             last_res;
    } match_rec_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = CFG_PATTERN_CHARS;
    logic [PAT_W-1:0]      cfg_data  = '0;

    // shadow of the search registers, as the block holds them
    logic [PAT_W-1:0]  pattern_reg = '0;
    logic [PLEN_W-1:0] pat_len_reg = 4'd1;

    text_beat_t  text_beats [$];
    logic [7:0]  text_bytes [$];
    match_rec_t  expected_results [$];

    int src_gap_max = 19;
    int snk_gap_max = 19;
    int src_wait    = 0;
    int snk_wait    = 0;
    int hold_left   = 0;
    logic hold_req  = 1'b0;
    int errors      = 0;
    int quiet_cycles = 0;

    bad_character_pattern_search u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int eff_len(input logic [PLEN_W-1:0] len);
        if (len == 0)
            return 1;
        if (len > DEF_MAX_PATTERN)
            return DEF_MAX_PATTERN;
        return int'(len);
    endfunction

    // bad-character search over the stored run, queues the beats it yields
    function automatic void find_matches();
        int               m, n, s, j, sh, i;
        logic [7:0]       c;
        bit               seen [256];
        int               last_at [256];
        logic [MC_W-1:0]  hits;
        logic [CMP_W-1:0] cmps;
        match_rec_t       r;
        m = eff_len(pat_len_reg);
        n = text_bytes.size();
        for (i = 0; i < 256; i++)
        begin
            seen[i]    = 1'b0;
            last_at[i] = 0;
        end
        for (i = 0; i < m; i++)
        begin
            c          = pattern_reg[8*i +: 8];
            seen[c]    = 1'b1;
            last_at[c] = i;
        end
        hits = '0;
        cmps = '0;
        s    = 0;
        while (n >= m && s <= n - m)
        begin
            j = m - 1;
            while (j >= 0 && pattern_reg[8*j +: 8] == text_bytes[s+j])
            begin
                j--;
                if (cmps != CMP_MAX)
                    cmps++;
            end
            if (j < 0)
            begin
                if (hits < DEF_MAX_REPORTED)
                begin
                    r          = '0;
                    r.kind     = KIND_POSITION;
                    r.position = POS_W'(s);
                    expected_results.push_back(r);
                end
                if (hits != MATCH_MAX)
                    hits++;
                // shift on the byte just past the window, if there is one
                if (s + m < n)
                begin
                    c = text_bytes[s+m];
                    s += seen[c] ? m - last_at[c] : m + 1;
                end
                else
                    s++;
            end
            else
            begin
                c = text_bytes[s+j];
                if (cmps != CMP_MAX)
                    cmps++;
                sh = seen[c] ? j - last_at[c] : j + 1;
                s += (sh < 1) ? 1 : sh;
            end
        end
        r             = '0;
        r.kind        = KIND_SUMMARY;
        r.match_count = hits;
        r.comparisons = cmps;
        r.dropped     = (hits > DEF_MAX_REPORTED);
        r.last_res    = 1'b1;
        expected_results.push_back(r);
        text_bytes.delete();
    endfunction

    // text source
    always @(posedge clk or negedge rst_n)
    begin : source
        text_beat_t nb;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            src_wait = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (text_bytes.size() < DEF_TEXT_DEPTH)
                    text_bytes.push_back(s_tdata);
                if (s_tlast)
                    find_matches();
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_wait > 0)
                begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (text_beats.size() > 0)
                begin
                    nb = text_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nb.data;
                    s_tlast  <= nb.last;
                    src_wait = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, started by a one-cycle request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // result sink and checker
    always @(posedge clk or negedge rst_n)
    begin : sink
        match_rec_t want, got;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind        = m_tuser;
                got.position    = m_tdata[POS_W-1:0];
                got.match_count = m_tdata[POS_W +: MC_W];
                got.comparisons = m_tdata[POS_W+MC_W +: CMP_W];
                got.dropped     = m_tdata[POS_W+MC_W+CMP_W];
                got.last_res    = m_tlast;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: kind=%0d pos=%0d count=%0d cmp=%0d",
                                 got.kind, got.position, got.match_count, got.comparisons);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.position !== want.position ||
                        got.match_count !== want.match_count ||
                        got.comparisons !== want.comparisons ||
                        got.dropped !== want.dropped || got.last_res !== want.last_res)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $write("result beat differs: expected kind=%0d pos=%0d ",
                                   want.kind, want.position);
                            $write("count=%0d cmp=%0d drop=%0d last=%0d, ",
                                   want.match_count, want.comparisons, want.dropped,
                                   want.last_res);
                            $display("got kind=%0d pos=%0d count=%0d cmp=%0d drop=%0d last=%0d",
                                     got.kind, got.position, got.match_count,
                                     got.comparisons, got.dropped, got.last_res);
                        end
                    end
                end
                snk_wait = (snk_gap_max == 0) ? 0 : $urandom_range(0, snk_gap_max);
            end
            else if (snk_wait > 0)
                snk_wait--;
            m_tready <= (snk_wait == 0) && (hold_left == 0);
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("bad_character_pattern_search: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_text(input logic [7:0] b, input bit last);
        text_beat_t nb;
        nb.data = b;
        nb.last = last;
        text_beats.push_back(nb);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (text_beats.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // write both registers back to back once the block is idle
    task automatic configure(input logic [PAT_W-1:0] pat, input logic [PAT_W-1:0] len_word);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PATTERN_CHARS;
        cfg_data  <= pat;
        do
            @(posedge clk);
        while (!cfg_ready);
        pattern_reg = pat;
        cfg_index <= CFG_PATTERN_LENGTH;
        cfg_data  <= len_word;
        do
            @(posedge clk);
        while (!cfg_ready);
        pat_len_reg = len_word[PLEN_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    // one run: mostly pattern copies over a small alphabet, sometimes noise
    task automatic queue_run(input int nbytes, input logic [PAT_W-1:0] pat, input int m,
                             input logic [7:0] ab);
        int         style, k, cut, i;
        logic [7:0] b;
        style = $urandom_range(0, 9);
        k = 0;
        while (k < nbytes)
        begin
            if (style < 2)
            begin
                b = 8'($urandom_range(0, 255));
                push_text(b, k == nbytes - 1);
                k++;
            end
            else if (style == 2)
            begin
                push_text(pat[8*(k % m) +: 8], k == nbytes - 1);
                k++;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, m) : m;
                for (i = 0; i < cut && k < nbytes; i++)
                begin
                    push_text(pat[8*i +: 8], k == nbytes - 1);
                    k++;
                end
            end
            else
            begin
                b = ab + 8'($urandom_range(0, 3));
                push_text(b, k == nbytes - 1);
                k++;
            end
        end
    endtask

    initial
    begin : stimulus
        int               fed, nruns, r, nbytes, i, k;
        bit               pressed;
        logic [7:0]       ab;
        logic [PAT_W-1:0] pat, len_word;
        logic [PLEN_W-1:0] len;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset registers: single NUL byte pattern
        push_text(8'h00, 0);
        push_text(8'hFF, 0);
        push_text(8'h00, 1);

        // length zero acts as one
        configure(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0);
        push_text(8'hFF, 0);
        push_text(8'h00, 0);
        push_text(8'hFF, 1);

        // length above the maximum saturates; match window ends at text end
        configure(64'h4847_4645_4443_4241, 64'h0000_0000_0000_000F);
        for (i = 0; i < 8; i++)
            push_text(8'h41 + 8'(i), i == 7);

        // text shorter than the pattern
        configure(64'h0, 64'h4);
        push_text(8'h00, 0);
        push_text(8'h00, 1);

        // overlapping matches, shift on the byte past the window
        configure(64'h0000_0000_0061_6261, 64'h3);
        push_text(8'h61, 0);
        push_text(8'h62, 0);
        push_text(8'h61, 0);
        push_text(8'h62, 0);
        push_text(8'h61, 1);

        fed     = 0;
        pressed = 1'b0;
        while (fed < 280)
        begin
            case ($urandom_range(0, 5))
                0:       len = 4'd1;
                1:       len = 4'd8;
                2:       len = 4'd0;
                3:       len = 4'($urandom_range(9, 15));
                default: len = 4'($urandom_range(2, 7));
            endcase
            ab = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                pat = {$urandom, $urandom};
            else
                for (i = 0; i < 8; i++)
                    pat[8*i +: 8] = ab + 8'($urandom_range(0, 2));
            len_word = {$urandom, $urandom};
            len_word[PLEN_W-1:0] = len;
            configure(pat, len_word);

            src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
            snk_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
            nruns = $urandom_range(1, 4);
            @(negedge clk);
            if (!pressed && fed >= 150)
            begin
                // stall the result side while runs keep arriving
                pressed     = 1'b1;
                src_gap_max = 0;
                nruns       = 4;
                hold_req <= 1'b1;
                @(negedge clk);
                hold_req <= 1'b0;
            end
            for (r = 0; r < nruns; r++)
            begin
                nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90)
                                                     : $urandom_range(1, 24);
                queue_run(nbytes, pat, eff_len(len), ab);
                fed += nbytes;
            end
        end

        // far more matches than reported
        configure(64'h5A, 64'h1);
        src_gap_max = 0;
        @(negedge clk);
        for (k = 0; k < 70; k++)
            push_text(8'h5A, k == 69);

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("bad_character_pattern_search: match");
        else
            $display("bad_character_pattern_search: mismatch");
        $finish;
    end

endmodule
